// ===== rtl/ternary_matrix_vector_unit_assert.svh =====
// Assertion macros shared by the ternary matrix-vector RTL.
// Expects clk and arst_n in the scope of the including module.
`ifndef TERNARY_MATRIX_VECTOR_UNIT_ASSERT_SVH
`define TERNARY_MATRIX_VECTOR_UNIT_ASSERT_SVH

// property checked every clock outside reset
`define TMV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define TMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tmv_pkg.sv =====
// Types and constants for the ternary matrix-vector unit.
// No dependencies; used by every module under rtl except tmv_ram.
package tmv_pkg;

	localparam int LANES      = 32;
	localparam int LANE_IDX_W = 5;
	localparam int CODE_W     = 2;
	localparam int ACT_W      = 8;
	localparam int ACT_IDX_W  = 12;
	localparam int TERM_W     = 9;
	localparam int PART_SIZE  = 8;
	localparam int PARTS      = LANES / PART_SIZE;
	localparam int PART_W     = 12;
	localparam int TOTAL_W    = 14;
	localparam int SUM_W      = 20;
	localparam int ROW_W      = 14;
	localparam int GROUP_W    = 7;
	localparam int COLS_CFG_W = 13;
	localparam int ROWS_CFG_W = 15;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 1;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_WEIGHT = 1'b1;

	localparam logic [CODE_W-1:0] CODE_PLUS  = 2'b01;
	localparam logic [CODE_W-1:0] CODE_MINUS = 2'b11;

	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

	localparam logic [COLS_CFG_W-1:0] COLS_RESET = 13'd4096;
	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 15'd4096;

	localparam logic [SUM_W-1:0] SUM_MAX = 20'h7FFFF;
	localparam logic [SUM_W-1:0] SUM_MIN = 20'h80000;

	typedef struct packed {
		logic                    command;
		logic [ACT_IDX_W-1:0]    act_index;
		logic signed [ACT_W-1:0] act_value;
		logic [LANES*CODE_W-1:0] weight_codes;
	} in_word_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] row_sum;
		logic [ROW_W-1:0]        row_index;
		logic                    last_row;
	} out_word_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic             end_row;
		logic             last;
		logic [ROW_W-1:0] row;
	} ctrl_t;

	typedef logic signed [TERM_W-1:0] term_t;

endpackage

// ===== rtl/tmv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic                                 rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/tmv_lane.sv =====
// One lane: a bank of the activation store plus the ternary term select.
// Depends on tmv_pkg and tmv_ram.
module tmv_lane #(
	parameter int DEPTH = 128
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [tmv_pkg::ACT_W-1:0]            wr_data,
	input  logic                                 rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	input  logic [tmv_pkg::CODE_W-1:0]           code,
	output tmv_pkg::term_t                       term
);

	logic [tmv_pkg::ACT_W-1:0] act;
	tmv_pkg::term_t            act_ext;

	tmv_ram #(
		.WIDTH (tmv_pkg::ACT_W),
		.DEPTH (DEPTH)
	) u_bank (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (act)
	);

	// nine bits so that -128 negates to +128
	assign act_ext = {act[tmv_pkg::ACT_W-1], act};

	always_comb begin
		case (code)
			tmv_pkg::CODE_PLUS:  term = act_ext;
			tmv_pkg::CODE_MINUS: term = -act_ext;
			default:             term = '0;
		endcase
	end

endmodule

// ===== rtl/tmv_merge.sv =====
// Merge stage: adds the lane terms, accumulates the row and holds the output word.
// Depends on tmv_pkg and the assertion header.
`include "ternary_matrix_vector_unit_assert.svh"

module tmv_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  tmv_pkg::ctrl_t      ctrl_s1,
	input  tmv_pkg::term_t      terms [tmv_pkg::LANES],
	output logic                adv,
	output logic                out_valid,
	input  logic                out_ready,
	output tmv_pkg::out_word_t  out_data
);

	logic                               valid_s2;
	tmv_pkg::ctrl_t                     ctrl_s2;
	logic signed [tmv_pkg::PART_W-1:0]  part_s2 [tmv_pkg::PARTS];
	logic signed [tmv_pkg::PART_W-1:0]  part    [tmv_pkg::PARTS];
	logic signed [tmv_pkg::TOTAL_W-1:0] total;
	logic signed [tmv_pkg::SUM_W:0]     acc_wide;
	logic [tmv_pkg::SUM_W-1:0]          acc_sat;
	logic [tmv_pkg::SUM_W-1:0]          acc_q;
	logic                               out_valid_q;
	tmv_pkg::out_word_t                 out_data_q;
	logic                               load_out;

	// first level of the tree: groups of eight lanes
	always_comb begin
		for (int p = 0; p < tmv_pkg::PARTS; p++) begin
			part[p] = '0;
			for (int j = 0; j < tmv_pkg::PART_SIZE; j++) begin
				part[p] = part[p] + tmv_pkg::PART_W'(terms[p*tmv_pkg::PART_SIZE + j]);
			end
		end
	end

	always_comb begin
		total = '0;
		for (int p = 0; p < tmv_pkg::PARTS; p++) begin
			total = total + tmv_pkg::TOTAL_W'(part_s2[p]);
		end
	end

	assign acc_wide = {acc_q[tmv_pkg::SUM_W-1], acc_q}
		+ {{(tmv_pkg::SUM_W + 1 - tmv_pkg::TOTAL_W){total[tmv_pkg::TOTAL_W-1]}}, total};

	always_comb begin
		if (acc_wide[tmv_pkg::SUM_W] != acc_wide[tmv_pkg::SUM_W-1]) begin
			acc_sat = acc_wide[tmv_pkg::SUM_W] ? tmv_pkg::SUM_MIN : tmv_pkg::SUM_MAX;
		end else begin
			acc_sat = acc_wide[tmv_pkg::SUM_W-1:0];
		end
	end

	// only a row end that finds the output word still occupied stalls the pipe
	assign adv      = !(valid_s2 && ctrl_s2.end_row && out_valid_q && !out_ready);
	assign load_out = adv && valid_s2 && ctrl_s2.end_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s2 <= ctrl_s1;
			part_s2 <= part;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && valid_s2) begin
			acc_q <= ctrl_s2.end_row ? '0 : acc_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.row_sum   <= acc_sat;
			out_data_q.row_index <= ctrl_s2.row;
			out_data_q.last_row  <= ctrl_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`TMV_ASSERT_NEXT(a_acc_clear, load_out, acc_q == '0, "accumulator not cleared at row end")
	`TMV_ASSERT(a_no_overwrite, load_out |-> (!out_valid_q || out_ready), "output word overwritten")
	`TMV_ASSERT_NEXT(a_stage_holds, !adv && valid_s2, valid_s2 && $stable(ctrl_s2), "stage lost")

endmodule

// ===== rtl/ternary_matrix_vector_unit.sv =====
// Top level of the ternary-weight matrix-vector unit.
// Depends on tmv_pkg, tmv_lane, tmv_merge and the assertion header.
//
// Usage:
//   Input words (in_valid/in_ready) either load one activation (command 0)
//   or carry 32 ternary weights for the next column group of the current row
//   (command 1). A load gives no output. The last group of a row produces one
//   output word (out_valid/out_ready) with the row sum, row index and a
//   last-row flag; the row counter then advances or wraps.
//   Configuration (cfg_wr_en, cfg_index, cfg_data) sets the columns per row
//   and rows per pass; write it only while the unit is idle.
//   Throughput: one input word per cycle while in_ready is high. The 32 lanes
//   each read their own bank of the activation store, so a whole column group
//   is read at once. A row-ending weight word passes the bank read, the lane
//   add tree and the accumulate into the output register before its output
//   word shows. A load is visible to a weight word accepted in the next cycle.
//   Reset clears the counters and accumulator and restores the default
//   configuration; the activation store keeps no reset value and must be
//   loaded before use.
//   Stall: input words keep flowing while an output word waits; only a
//   second row end reaching the full output register holds in_ready low.
`include "ternary_matrix_vector_unit_assert.svh"

module ternary_matrix_vector_unit #(
	parameter int COLS_MAX = 4096,
	parameter int ROWS_MAX = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tmv_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tmv_pkg::out_word_t                  out_data,
	input  logic                                cfg_wr_en,
	input  logic [tmv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tmv_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int STORE_LIMIT = 2 ** tmv_pkg::ACT_IDX_W;
	localparam int STORE_DEPTH = (COLS_MAX < STORE_LIMIT) ? COLS_MAX : STORE_LIMIT;
	localparam int BANK_DEPTH  = (STORE_DEPTH + tmv_pkg::LANES - 1) / tmv_pkg::LANES;
	localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int GMAX        = COLS_MAX / tmv_pkg::LANES;
	localparam int GW          = 12;
	localparam int RW          = 17;

	logic [tmv_pkg::COLS_CFG_W-1:0] cols_q;
	logic [tmv_pkg::ROWS_CFG_W-1:0] rows_q;
	logic [tmv_pkg::GROUP_W-1:0]    cg_q;
	logic [tmv_pkg::ROW_W-1:0]      row_q;

	logic            adv;
	logic            accept;
	logic            accept_w;
	logic            load_ok;
	logic [GW-1:0]   groups;
	logic [GW-1:0]   cols_groups;
	logic [RW-1:0]   rows;
	logic            end_row;
	logic            last;

	logic                                 valid_s1;
	tmv_pkg::ctrl_t                       ctrl_s1;
	logic [tmv_pkg::CODE_W-1:0]           code_s1 [tmv_pkg::LANES];
	logic [tmv_pkg::CODE_W-1:0]           code_s0 [tmv_pkg::LANES];
	tmv_pkg::term_t                       terms   [tmv_pkg::LANES];

	assign in_ready = adv;
	assign accept   = in_valid && adv;
	assign accept_w = accept && (in_data.command == tmv_pkg::CMD_WEIGHT);
	assign load_ok  = accept && (in_data.command == tmv_pkg::CMD_LOAD)
		&& ({1'b0, in_data.act_index} < (tmv_pkg::ACT_IDX_W + 1)'(STORE_DEPTH));

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= tmv_pkg::COLS_RESET;
			rows_q <= tmv_pkg::ROWS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tmv_pkg::REG_COLS: cols_q <= cfg_data[tmv_pkg::COLS_CFG_W-1:0];
				tmv_pkg::REG_ROWS: rows_q <= cfg_data[tmv_pkg::ROWS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// group count: columns / 32, clamped to 1..COLS_MAX/32
	assign cols_groups = GW'(cols_q[tmv_pkg::COLS_CFG_W-1:tmv_pkg::LANE_IDX_W]);

	always_comb begin
		if (cols_groups == '0) begin
			groups = GW'(1);
		end else if (cols_groups > GW'(GMAX)) begin
			groups = GW'(GMAX);
		end else begin
			groups = cols_groups;
		end
	end

	always_comb begin
		if (rows_q == '0) begin
			rows = RW'(1);
		end else if (RW'(rows_q) > RW'(ROWS_MAX)) begin
			rows = RW'(ROWS_MAX);
		end else begin
			rows = RW'(rows_q);
		end
	end

	assign end_row = (GW'(cg_q) + GW'(1)) >= groups;
	assign last    = (RW'(row_q) + RW'(1)) >= rows;

	// ---------------- row and column counters ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cg_q  <= '0;
			row_q <= '0;
		end else if (accept_w) begin
			if (end_row) begin
				cg_q  <= '0;
				row_q <= last ? '0 : row_q + 1'b1;
			end else begin
				cg_q <= cg_q + 1'b1;
			end
		end
	end

	// columns at or past COLS_MAX add nothing: force their codes to zero
	always_comb begin
		for (int k = 0; k < tmv_pkg::LANES; k++) begin
			if (RW'({cg_q, tmv_pkg::LANE_IDX_W'(k)}) < RW'(COLS_MAX)) begin
				code_s0[k] = in_data.weight_codes[k*tmv_pkg::CODE_W +: tmv_pkg::CODE_W];
			end else begin
				code_s0[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s1.end_row <= end_row;
			ctrl_s1.last    <= last;
			ctrl_s1.row     <= row_q;
			code_s1         <= code_s0;
		end
	end

	// ---------------- lanes ----------------
	for (genvar k = 0; k < tmv_pkg::LANES; k++) begin : g_lane
		logic lane_wr;

		assign lane_wr = load_ok
			&& (in_data.act_index[tmv_pkg::LANE_IDX_W-1:0] == tmv_pkg::LANE_IDX_W'(k));

		tmv_lane #(
			.DEPTH (BANK_DEPTH)
		) u_lane (
			.clk     (clk),
			.wr_en   (lane_wr),
			.wr_addr (in_data.act_index[tmv_pkg::LANE_IDX_W +: AW]),
			.wr_data (in_data.act_value),
			.rd_en   (adv),
			.rd_addr (cg_q[AW-1:0]),
			.code    (code_s1[k]),
			.term    (terms[k])
		);
	end

	tmv_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ctrl_s1   (ctrl_s1),
		.terms     (terms),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`TMV_ASSERT_NEXT(a_cg_wrap, accept_w && end_row, cg_q == '0, "column group not cleared")
	`TMV_ASSERT_NEXT(a_cg_step, accept_w && !end_row, cg_q == $past(cg_q) + 1'b1, "column group skip")
	`TMV_ASSERT_NEXT(a_row_hold, !(accept_w && end_row), $stable(row_q), "row counter moved mid-row")

endmodule
